### hw/rtl/bchq_pkg.sv
// Package for the button click and hold qualifier.
// Holds field widths, command and flag codes, history patterns and shared types.
// No dependencies.
package bchq_pkg;

   localparam int CMD_W     = 3;
   localparam int LEVEL_W   = 8;
   localparam int BUTTON_W  = 3;
   localparam int FLAG_W    = 5;
   localparam int HIST_W    = 8;
   localparam int TIMER_W   = 14;
   localparam int STEP_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 14;
   localparam int MASK_W    = 8;

   localparam int NUM_BUTTONS_DEF = 8;

   localparam logic [CMD_W-1:0] CMD_SAMPLE      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TEST_HELD   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TEST_CLICK  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TEST_ACTIVE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

   localparam int F_PRESSED  = 0;
   localparam int F_RELEASED = 1;
   localparam int F_ACTIVE   = 2;
   localparam int F_INACTIVE = 3;
   localparam int F_HELD     = 4;

   localparam logic [HIST_W-1:0] PAT_RISE = 8'b0111_1111;
   localparam logic [HIST_W-1:0] PAT_FALL = 8'b1111_1110;
   localparam logic [HIST_W-1:0] PAT_HIGH = 8'b1111_1111;
   localparam logic [HIST_W-1:0] PAT_LOW  = 8'b0000_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_PRESET   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_STEP     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_CAP      = 2'd3;

   localparam logic [TIMER_W-1:0] RST_HOLD_THRESHOLD = 14'd2000;
   localparam logic [TIMER_W-1:0] RST_PRESS_PRESET   = 14'd35;
   localparam logic [STEP_W-1:0]  RST_TIMER_STEP     = 8'd5;
   localparam logic [TIMER_W-1:0] RST_TIMER_CAP      = 14'd10000;

   typedef struct packed {
      logic [TIMER_W-1:0] hold_threshold;
      logic [TIMER_W-1:0] press_preset;
      logic [STEP_W-1:0]  timer_step;
      logic [TIMER_W-1:0] timer_cap;
   } cfg_type;

   typedef struct packed {
      logic              accept;
      logic [CMD_W-1:0]  cmd;
      logic              sel;
      logic              level;
      logic [FLAG_W-1:0] clear_mask;
   } lane_ctl_type;

   typedef struct packed {
      logic hit;
      logic active;
   } lane_res_type;

endpackage

### hw/rtl/bchq_if.sv
// Handshake channel interfaces for the button click and hold qualifier.
// Depends on bchq_pkg for field widths.
interface bchq_req_if;
   logic                            valid;
   logic                            ready;
   logic [bchq_pkg::CMD_W-1:0]      cmd;
   logic [bchq_pkg::LEVEL_W-1:0]    levels;
   logic [bchq_pkg::BUTTON_W-1:0]   button;
   logic [bchq_pkg::FLAG_W-1:0]     clear_mask;

   modport source (output valid, cmd, levels, button, clear_mask, input ready);
   modport sink   (input valid, cmd, levels, button, clear_mask, output ready);
endinterface

interface bchq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [bchq_pkg::MASK_W-1:0]   active_mask;

   modport source (output valid, hit, active_mask, input ready);
   modport sink   (input valid, hit, active_mask, output ready);
endinterface

### hw/rtl/bchq_lane.sv
// One button lane: level history, status flags and press timer with their update.
// Depends on bchq_pkg.
module bchq_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  bchq_pkg::cfg_type      cfg,
   input  bchq_pkg::lane_ctl_type ctl,
   output bchq_pkg::lane_res_type res
);

   logic [bchq_pkg::HIST_W-1:0]  hist_ff,  hist_in;
   logic [bchq_pkg::FLAG_W-1:0]  flags_ff, flags_in;
   logic [bchq_pkg::TIMER_W-1:0] timer_ff, timer_in;
   logic [bchq_pkg::HIST_W-1:0]  hist_shift;
   logic [bchq_pkg::TIMER_W:0]   sum;
   logic                         hit;

   assign hist_shift = {hist_ff[bchq_pkg::HIST_W-2:0], ctl.level};
   assign sum = {1'b0, timer_ff} + {{(bchq_pkg::TIMER_W + 1 - bchq_pkg::STEP_W){1'b0}},
                                    cfg.timer_step};

   always_comb begin
      hist_in  = hist_ff;
      flags_in = flags_ff;
      timer_in = timer_ff;
      hit      = 1'b0;
      case (ctl.cmd)
         bchq_pkg::CMD_SAMPLE: begin
            hist_in = hist_shift;
            if (hist_shift == bchq_pkg::PAT_RISE) begin
               flags_in[bchq_pkg::F_PRESSED]  = 1'b1;
               flags_in[bchq_pkg::F_RELEASED] = 1'b0;
               flags_in[bchq_pkg::F_HELD]     = 1'b0;
               timer_in = cfg.press_preset;
            end else if (hist_shift == bchq_pkg::PAT_FALL) begin
               flags_in[bchq_pkg::F_RELEASED] = 1'b1;
               timer_in = '0;
            end else if (hist_shift == bchq_pkg::PAT_HIGH) begin
               if (flags_ff[bchq_pkg::F_PRESSED]) begin
                  flags_in[bchq_pkg::F_ACTIVE]   = 1'b1;
                  flags_in[bchq_pkg::F_INACTIVE] = 1'b0;
                  if (sum > {1'b0, cfg.hold_threshold}) begin
                     flags_in[bchq_pkg::F_HELD] = 1'b1;
                  end
                  if (sum > {1'b0, cfg.timer_cap}) begin
                     timer_in = cfg.timer_cap;
                  end else begin
                     timer_in = sum[bchq_pkg::TIMER_W-1:0];
                  end
               end
            end else if (hist_shift == bchq_pkg::PAT_LOW) begin
               flags_in[bchq_pkg::F_INACTIVE] = 1'b1;
               flags_in[bchq_pkg::F_ACTIVE]   = 1'b0;
               timer_in = '0;
            end
         end
         bchq_pkg::CMD_TEST_HELD: begin
            if (ctl.sel && flags_ff[bchq_pkg::F_HELD]) begin
               flags_in[bchq_pkg::F_HELD]    = 1'b0;
               flags_in[bchq_pkg::F_PRESSED] = 1'b0;
               hit = 1'b1;
            end
         end
         bchq_pkg::CMD_TEST_CLICK: begin
            if (ctl.sel && flags_ff[bchq_pkg::F_PRESSED] && flags_ff[bchq_pkg::F_RELEASED]) begin
               flags_in[bchq_pkg::F_PRESSED]  = 1'b0;
               flags_in[bchq_pkg::F_RELEASED] = 1'b0;
               flags_in[bchq_pkg::F_HELD]     = 1'b0;
               hit = 1'b1;
            end
         end
         bchq_pkg::CMD_TEST_ACTIVE: begin
            hit = ctl.sel & flags_ff[bchq_pkg::F_ACTIVE];
         end
         bchq_pkg::CMD_CLEAR: begin
            flags_in = flags_ff & ~ctl.clear_mask;
         end
         default: begin
         end
      endcase
   end

   assign res.hit    = hit;
   assign res.active = flags_in[bchq_pkg::F_ACTIVE];

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         flags_ff <= '0;
         timer_ff <= '0;
      end else if (ctl.accept) begin
         hist_ff  <= hist_in;
         flags_ff <= flags_in;
         timer_ff <= timer_in;
      end
   end

endmodule

### hw/rtl/bchq_merge.sv
// Merge stage: combines lane results into one result and holds it in an
// output register with a skid entry. Depends on bchq_pkg.
module bchq_merge #(
   parameter int NUM_BUTTONS = bchq_pkg::NUM_BUTTONS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  bchq_pkg::lane_res_type    res [NUM_BUTTONS],
   output logic                      in_ready,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic                      out_hit,
   output logic [bchq_pkg::MASK_W-1:0] out_mask
);

   logic [NUM_BUTTONS-1:0]          hits;
   logic                            hit_new;
   logic [bchq_pkg::MASK_W-1:0]     mask_new;
   logic                            main_valid_ff, main_valid_in;
   logic                            skid_valid_ff, skid_valid_in;
   logic                            main_hit_ff, main_hit_in;
   logic                            skid_hit_ff, skid_hit_in;
   logic [bchq_pkg::MASK_W-1:0]     main_mask_ff, main_mask_in;
   logic [bchq_pkg::MASK_W-1:0]     skid_mask_ff, skid_mask_in;
   logic                            take;

   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_hits
      assign hits[b] = res[b].hit;
   end

   for (genvar m = 0; m < bchq_pkg::MASK_W; m++) begin : g_mask
      if (m < NUM_BUTTONS) begin : g_on
         assign mask_new[m] = res[m].active;
      end else begin : g_off
         assign mask_new[m] = 1'b0;
      end
   end

   assign hit_new = |hits;
   assign take    = main_valid_ff & out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_hit_in   = main_hit_ff;
      main_mask_in  = main_mask_ff;
      skid_valid_in = skid_valid_ff;
      skid_hit_in   = skid_hit_ff;
      skid_mask_in  = skid_mask_ff;
      if (take) begin
         main_valid_in = skid_valid_ff;
         main_hit_in   = skid_hit_ff;
         main_mask_in  = skid_mask_ff;
         skid_valid_in = 1'b0;
      end
      if (accept) begin
         if (!main_valid_ff || take) begin
            main_valid_in = 1'b1;
            main_hit_in   = hit_new;
            main_mask_in  = mask_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_hit_in   = hit_new;
            skid_mask_in  = mask_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_hit_ff  <= main_hit_in;
      main_mask_ff <= main_mask_in;
      skid_hit_ff  <= skid_hit_in;
      skid_mask_ff <= skid_mask_in;
   end

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_hit   = main_hit_ff;
   assign out_mask  = main_mask_ff;

endmodule

### hw/rtl/button_click_hold_qualifier.sv
// Button click and hold qualifier top level.
// Depends on bchq_pkg, bchq_if, bchq_lane and bchq_merge.
//
// Usage: each transfer on the req channel is one command. A sample command
// shifts the levels field into every button's history; the test commands
// check and consume the held or click flags of one button or read its active
// flag; the clear command clears the chosen flags on all buttons. Every
// command produces exactly one transfer on the rsp channel carrying the hit
// bit and the active flags of buttons 0 to 7 after the command.
// One command is taken every cycle while req.ready is high; all button lanes
// update in parallel in the accepting cycle. When the receiver stalls, one
// more result is held in a skid entry and req.ready then drops until the rsp
// side drains it. Registers are written through the csr port while the block
// is idle; the user must keep to this, as the block does not enforce it.
// Synchronous reset clears all histories, flags and timers, empties the
// output stage and loads the register defaults.
module button_click_hold_qualifier #(
   parameter int NUM_BUTTONS = bchq_pkg::NUM_BUTTONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   bchq_req_if.sink                        req,
   bchq_rsp_if.source                      rsp,
   input  logic                            csr_wr_en,
   input  logic [bchq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bchq_pkg::CSR_W-1:0]      csr_wdata
);

   bchq_pkg::cfg_type      cfg_ff;
   bchq_pkg::lane_res_type lane_res [NUM_BUTTONS];
   logic                   accept;
   logic                   in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_threshold <= bchq_pkg::RST_HOLD_THRESHOLD;
         cfg_ff.press_preset   <= bchq_pkg::RST_PRESS_PRESET;
         cfg_ff.timer_step     <= bchq_pkg::RST_TIMER_STEP;
         cfg_ff.timer_cap      <= bchq_pkg::RST_TIMER_CAP;
      end else if (csr_wr_en) begin
         case (csr_index)
            bchq_pkg::CSR_HOLD_THRESHOLD: cfg_ff.hold_threshold <= csr_wdata;
            bchq_pkg::CSR_PRESS_PRESET:   cfg_ff.press_preset   <= csr_wdata;
            bchq_pkg::CSR_TIMER_STEP:
               cfg_ff.timer_step <= csr_wdata[bchq_pkg::STEP_W-1:0];
            bchq_pkg::CSR_TIMER_CAP:      cfg_ff.timer_cap      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req.ready = in_ready;
   assign accept    = req.valid & in_ready;

   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
      bchq_pkg::lane_ctl_type ctl;

      assign ctl.accept     = accept;
      assign ctl.cmd        = req.cmd;
      assign ctl.clear_mask = req.clear_mask;
      if (b < bchq_pkg::LEVEL_W) begin : g_in
         assign ctl.level = req.levels[b];
         assign ctl.sel   = (req.button == bchq_pkg::BUTTON_W'(b));
      end else begin : g_out
         assign ctl.level = 1'b0;
         assign ctl.sel   = 1'b0;
      end

      bchq_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cfg   (cfg_ff),
         .ctl   (ctl),
         .res   (lane_res[b])
      );
   end

   bchq_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .res       (lane_res),
      .in_ready  (in_ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_hit   (rsp.hit),
      .out_mask  (rsp.active_mask)
   );

endmodule
